// ===== hw/rtl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the signed Euclidean modulus block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int FIELD_W = 32;   // width of the operand fields
    localparam int REM_W   = 31;   // width of the remainder field

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIV0    = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    // Per-item control that travels alongside the partial remainder
    typedef struct packed {
        t_status status;
        logic    neg;       // dividend was negative
    } t_ctrl;

endpackage

// ===== hw/rtl/sem_if.sv =====
// ----------------------------------------------------------------------------
// sem_in_if / sem_out_if
// Valid/ready channels carrying operand pairs in and modulus results out.
// ----------------------------------------------------------------------------
interface sem_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [sem_pkg::FIELD_W-1:0]       dividend;
    logic signed [sem_pkg::FIELD_W-1:0]       divisor;
    logic                                     dividend_known;
    logic                                     divisor_known;

    modport source (output valid, dividend, divisor, dividend_known, divisor_known,
                    input ready);
    modport sink   (input valid, dividend, divisor, dividend_known, divisor_known,
                    output ready);
endinterface

interface sem_out_if;
    logic                          valid;
    logic                          ready;
    logic [sem_pkg::REM_W-1:0]     remainder;
    sem_pkg::t_status              status;
    logic                          result_known;

    modport source (output valid, remainder, status, result_known, input ready);
    modport sink   (input valid, remainder, status, result_known, output ready);
endinterface

// ===== hw/rtl/sem_front.sv =====
// ----------------------------------------------------------------------------
// sem_front
// Input stage: classifies the operand pair and registers operand magnitudes.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int X_WIDTH = 32,
    parameter int Y_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sem_in_if.sink                i_in,
    input  logic                  i_ready,
    output logic                  o_valid,
    output sem_pkg::t_ctrl        o_ctrl,
    output logic [X_WIDTH-1:0]    o_xm,
    output logic [Y_WIDTH-1:0]    o_ym
);

    localparam int XI = (X_WIDTH < sem_pkg::FIELD_W) ? X_WIDTH : sem_pkg::FIELD_W;
    localparam int YI = (Y_WIDTH < sem_pkg::FIELD_W) ? Y_WIDTH : sem_pkg::FIELD_W;

    logic                 r_valid;
    sem_pkg::t_ctrl       r_ctrl;
    logic [X_WIDTH-1:0]   r_xm;
    logic [Y_WIDTH-1:0]   r_ym;

    sem_pkg::t_ctrl       n_ctrl;
    logic [X_WIDTH-1:0]   n_xm;
    logic [Y_WIDTH-1:0]   n_ym;
    logic [X_WIDTH-1:0]   xraw;
    logic [Y_WIDTH-1:0]   yraw;
    logic                 load;

    assign load       = !r_valid || i_ready;
    assign i_in.ready = load;

    always_comb begin
        // Field bits above the parameter width are dropped; a narrower field
        // zero-extends into a wider operand.
        xraw = X_WIDTH'(i_in.dividend[XI-1:0]);
        yraw = Y_WIDTH'(i_in.divisor[YI-1:0]);
        n_xm = xraw[X_WIDTH-1] ? (~xraw + X_WIDTH'(1)) : xraw;
        n_ym = yraw[Y_WIDTH-1] ? (~yraw + Y_WIDTH'(1)) : yraw;
        n_ctrl.neg = xraw[X_WIDTH-1];
        if (!i_in.dividend_known || !i_in.divisor_known) begin
            n_ctrl.status = sem_pkg::ST_UNKNOWN;
        end else if (yraw == '0) begin
            n_ctrl.status = sem_pkg::ST_DIV0;
        end else begin
            n_ctrl.status = sem_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in.valid) begin
            r_ctrl <= n_ctrl;
            r_xm   <= n_xm;
            r_ym   <= n_ym;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_xm    = r_xm;
    assign o_ym    = r_ym;

endmodule

// ===== hw/rtl/sem_cell.sv =====
// ----------------------------------------------------------------------------
// sem_cell
// One restoring-division step: shifts in the next dividend bit and subtracts
// the divisor magnitude when it fits.
// ----------------------------------------------------------------------------
module sem_cell #(
    parameter int X_WIDTH = 32,
    parameter int Y_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sem_pkg::t_ctrl        i_ctrl,
    input  logic [Y_WIDTH-1:0]    i_p,
    input  logic [X_WIDTH-1:0]    i_x,
    input  logic [Y_WIDTH-1:0]    i_ym,
    input  logic                  i_ready,
    output logic                  o_valid,
    output sem_pkg::t_ctrl        o_ctrl,
    output logic [Y_WIDTH-1:0]    o_p,
    output logic [X_WIDTH-1:0]    o_x,
    output logic [Y_WIDTH-1:0]    o_ym
);

    logic                 r_valid;
    sem_pkg::t_ctrl       r_ctrl;
    logic [Y_WIDTH-1:0]   r_p;
    logic [X_WIDTH-1:0]   r_x;
    logic [Y_WIDTH-1:0]   r_ym;

    logic [Y_WIDTH:0]     trial;
    logic [Y_WIDTH:0]     diff;
    logic [Y_WIDTH-1:0]   n_p;
    logic                 load;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;

    always_comb begin
        trial = {i_p, i_x[X_WIDTH-1]};
        diff  = trial - {1'b0, i_ym};
        // Partial remainder stays below the divisor, so the difference fits
        n_p   = (trial >= {1'b0, i_ym}) ? diff[Y_WIDTH-1:0] : trial[Y_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_ctrl <= i_ctrl;
            r_p    <= n_p;
            r_x    <= {i_x[X_WIDTH-2:0], 1'b0};
            r_ym   <= i_ym;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_p     = r_p;
    assign o_x     = r_x;
    assign o_ym    = r_ym;

endmodule

// ===== hw/rtl/sem_back.sv =====
// ----------------------------------------------------------------------------
// sem_back
// Output stage: folds a negative dividend into the Euclidean range and holds
// the result for the receiver.
// ----------------------------------------------------------------------------
module sem_back #(
    parameter int Y_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sem_pkg::t_ctrl        i_ctrl,
    input  logic [Y_WIDTH-1:0]    i_p,
    input  logic [Y_WIDTH-1:0]    i_ym,
    sem_out_if.source             o_out
);

    localparam int RW = sem_pkg::REM_W;
    localparam int RI = (Y_WIDTH < RW) ? Y_WIDTH : RW;

    logic                 r_valid;
    logic [RW-1:0]        r_rem;
    sem_pkg::t_status     r_status;
    logic                 r_known;

    logic [Y_WIDTH-1:0]   fix;
    logic [RW-1:0]        n_rem;
    logic                 load;

    assign load    = !r_valid || o_out.ready;
    assign o_ready = load;

    always_comb begin
        fix = (i_ctrl.neg && (i_p != '0)) ? (i_ym - i_p) : i_p;
        // Force zero on anything but a good result
        n_rem = (i_ctrl.status == sem_pkg::ST_OK) ? RW'(fix[RI-1:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_rem    <= n_rem;
            r_status <= i_ctrl.status;
            r_known  <= (i_ctrl.status == sem_pkg::ST_OK);
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.remainder    = r_rem;
    assign o_out.status       = r_status;
    assign o_out.result_known = r_known;

endmodule

// ===== hw/rtl/signed_euclidean_modulus.sv =====
// ----------------------------------------------------------------------------
// signed_euclidean_modulus
// Euclidean modulus of a signed dividend by a signed divisor, pipelined.
// ----------------------------------------------------------------------------
// Operand pairs arrive on i_in (valid/ready); a pair transfers when both are
// high. Each pair gives exactly one result on o_out, in order.
// The result is 0 <= remainder < |divisor| with status ok, or a zeroed
// remainder with status divide-by-zero or operand-unknown.
// The pipeline is one input stage, one division cell per dividend bit and
// one output register. A new pair is taken every cycle unless a stalled
// receiver has filled the chain; the chain has X_WIDTH cells, each a
// Y_WIDTH-bit compare and subtract.
// Each stage holds its item while the next one is full and stalled; empty
// stages fill up, so the block keeps taking pairs until every stage holds one.
// When the receiver stalls, the result on o_out holds unchanged.
// Synchronous reset empties every stage; no result is pending afterward.
// ----------------------------------------------------------------------------
module signed_euclidean_modulus #(
    parameter int X_WIDTH = 32,
    parameter int Y_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sem_in_if.sink       i_in,
    sem_out_if.source    o_out
);

    logic                 w_valid [X_WIDTH+1];
    logic                 w_rdy   [X_WIDTH+1];
    sem_pkg::t_ctrl       w_ctrl  [X_WIDTH+1];
    logic [Y_WIDTH-1:0]   w_p     [X_WIDTH+1];
    logic [X_WIDTH-1:0]   w_x     [X_WIDTH+1];
    logic [Y_WIDTH-1:0]   w_ym    [X_WIDTH+1];

    assign w_p[0] = '0;

    sem_front #(
        .X_WIDTH (X_WIDTH),
        .Y_WIDTH (Y_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (w_rdy[0]),
        .o_valid (w_valid[0]),
        .o_ctrl  (w_ctrl[0]),
        .o_xm    (w_x[0]),
        .o_ym    (w_ym[0])
    );

    for (genvar k = 0; k < X_WIDTH; k++) begin : g_cell
        sem_cell #(
            .X_WIDTH (X_WIDTH),
            .Y_WIDTH (Y_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_rdy[k]),
            .i_ctrl  (w_ctrl[k]),
            .i_p     (w_p[k]),
            .i_x     (w_x[k]),
            .i_ym    (w_ym[k]),
            .i_ready (w_rdy[k+1]),
            .o_valid (w_valid[k+1]),
            .o_ctrl  (w_ctrl[k+1]),
            .o_p     (w_p[k+1]),
            .o_x     (w_x[k+1]),
            .o_ym    (w_ym[k+1])
        );
    end

    sem_back #(
        .Y_WIDTH (Y_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[X_WIDTH]),
        .o_ready (w_rdy[X_WIDTH]),
        .i_ctrl  (w_ctrl[X_WIDTH]),
        .i_p     (w_p[X_WIDTH]),
        .i_ym    (w_ym[X_WIDTH]),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/sem_checker.sv =====
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks for the signed Euclidean modulus block.
// ----------------------------------------------------------------------------
module sem_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [sem_pkg::REM_W-1:0]   i_out_remainder,
    input  logic [1:0]                  i_out_status,
    input  logic                        i_out_result_known
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_remainder)
            && $stable(i_out_status) && $stable(i_out_result_known))
        else $error("result changed while stalled");

    a_known_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_result_known == (i_out_status == sem_pkg::ST_OK)))
        else $error("result_known disagrees with status");

    a_rem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != sem_pkg::ST_OK) |-> (i_out_remainder == '0))
        else $error("nonzero remainder on a failed result");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result pending right after reset");

    // With no result waiting, nothing in the chain can block the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output");

endmodule

bind signed_euclidean_modulus sem_checker u_sem_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_remainder    (o_out.remainder),
    .i_out_status       (o_out.status),
    .i_out_result_known (o_out.result_known)
);
